[rtl/pdg_pkg.sv]
`default_nettype none

package pdg_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RATIO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

    // Pitch ratio limits and reset values.
    localparam logic [15:0] RATIO_MIN   = 16'd29491;
    localparam logic [15:0] RATIO_MAX   = 16'd49152;
    localparam logic [15:0] RATIO_RESET = 16'd32768;
    localparam logic [1:0]  CHAN_RESET  = 2'd2;

    // Mix coefficients in Q0.16, held as positive signed multiplier operands.
    localparam logic signed [17:0] COEF_PITCHED = 18'sd45875;
    localparam logic signed [17:0] COEF_LOWPASS = 18'sd26214;
    localparam logic signed [17:0] COEF_DRY     = 18'sd13107;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic               last_frame;
    } in_frame_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               last_frame_out;
    } out_frame_t;

endpackage

`default_nettype wire

[rtl/pitch_down_growl_effect_unit.sv]
// A frame is accepted in ST_IDLE; the sequencer then steps the single shared multiplier
// through interpolation and the mix products, and no new frame is taken until the result
// has been loaded into the output register.
// Reset (rst_n, asynchronous, active low) sets all control state to its reset values and
// then runs a clearing pass that zeroes every ring address before the first input is taken.
`default_nettype none

module pitch_down_growl_effect_unit
    import pdg_pkg::*;
#(
    parameter int RING_FRAMES = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_frame_t             in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_frame_t                 out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Ring address width, and the width of the read lag: an integer part that can
    // hold RING_FRAMES itself, plus sixteen fractional bits.
    localparam int AW     = $clog2(RING_FRAMES);
    localparam int LAG_IW = $clog2(RING_FRAMES + 1);
    localparam int LAG_W  = LAG_IW + 16;
    localparam int ACC_W  = 50;

    localparam logic [AW-1:0]     LAST_ADDR = AW'(RING_FRAMES - 1);
    localparam logic [LAG_IW-1:0] RING_INT  = LAG_IW'(RING_FRAMES);
    localparam logic [AW:0]       RING_WIDE = (AW + 1)'(RING_FRAMES);
    localparam logic [LAG_W-1:0]  LAG_LIMIT = LAG_W'(RING_FRAMES) << 16;
    localparam logic [LAG_W-1:0]  LAG_HALF  = LAG_W'(RING_FRAMES / 2) << 16;

    // The sequencer. After a frame is accepted its samples are written to the ring,
    // the two neighbouring frames are read, and each channel then runs through the
    // interpolate, low-pass and mix steps on the shared multiplier.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_INTERP,
        ST_PITCH,
        ST_GROWL,
        ST_MIX_LP,
        ST_MIX_DRY,
        ST_MIX_SUM,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] ratio_reg, ratio_next;
    logic [1:0]  chan_cnt_reg, chan_cnt_next;

    // Persistent effect state.
    logic [AW-1:0]        wpos_reg, wpos_next;
    logic [LAG_W-1:0]     lag_reg, lag_next;
    logic signed [32:0]   growl_reg, growl_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;

    // Per-frame working registers.
    logic [AW-1:0]        pos_a_reg, pos_a_next;
    logic [AW-1:0]        pos_b_reg, pos_b_next;
    logic [15:0]          frac_reg, frac_next;
    logic                 stereo_reg, stereo_next;
    logic                 last_reg, last_next;
    logic signed [15:0]   dry_l_reg, dry_l_next;
    logic signed [15:0]   dry_r_reg, dry_r_next;
    logic signed [15:0]   a_l_reg, a_l_next;
    logic signed [15:0]   a_r_reg, a_r_next;
    logic signed [15:0]   b_r_reg, b_r_next;
    logic                 chan_reg, chan_next;
    logic signed [31:0]   pitched_reg, pitched_next;
    logic signed [50:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [15:0]   res_l_reg, res_l_next;
    logic signed [15:0]   res_r_reg, res_r_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    out_frame_t           out_data_reg, out_data_next;

    // Ring memories, one per channel.
    logic                 ram_we_l, ram_we_r;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [15:0]          ram_wdata_l, ram_wdata_r;
    logic [15:0]          ram_rdata_l, ram_rdata_r;

    pdg_ram #(
        .WIDTH (16),
        .DEPTH (RING_FRAMES)
    ) u_ram_left (
        .clk   (clk),
        .we    (ram_we_l),
        .waddr (ram_waddr),
        .wdata (ram_wdata_l),
        .raddr (ram_raddr),
        .rdata (ram_rdata_l)
    );

    pdg_ram #(
        .WIDTH (16),
        .DEPTH (RING_FRAMES)
    ) u_ram_right (
        .clk   (clk),
        .we    (ram_we_r),
        .waddr (ram_waddr),
        .wdata (ram_wdata_r),
        .raddr (ram_raddr),
        .rdata (ram_rdata_r)
    );

    // The one shared multiplier: a 33-bit signed operand times an 18-bit signed one.
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;

    assign mul_p = mul_a * mul_b;

    // Address arithmetic for a new frame. The read pointer sits read_lag behind the
    // write pointer; with a nonzero fraction the earlier frame is one further back and
    // the interpolation weight toward the later frame is 1 minus that fraction.
    logic                 accept;
    logic [LAG_IW-1:0]    lag_int;
    logic [15:0]          lag_frac;
    logic [LAG_IW-1:0]    back_full;
    logic [AW-1:0]        back_mod;
    logic [AW:0]          pos_a_wide;
    logic [AW-1:0]        pos_a_new;
    logic [LAG_W:0]       lag_sum;
    logic [15:0]          lag_step;

    assign accept   = in_valid && in_ready;
    assign lag_int  = lag_reg[LAG_W-1:16];
    assign lag_frac = lag_reg[15:0];
    assign lag_step = 16'(17'h10000 - {1'b0, ratio_reg});

    always_comb
    begin
        back_full = lag_int + LAG_IW'(lag_frac != 16'd0);
        if (back_full >= RING_INT)
        begin
            back_mod = AW'(back_full - RING_INT);
        end
        else
        begin
            back_mod = AW'(back_full);
        end
        if (wpos_reg >= back_mod)
        begin
            pos_a_wide = {1'b0, wpos_reg} - {1'b0, back_mod};
        end
        else
        begin
            pos_a_wide = {1'b0, wpos_reg} + RING_WIDE - {1'b0, back_mod};
        end
        pos_a_new = pos_a_wide[AW-1:0];
        lag_sum   = {1'b0, lag_reg} + (LAG_W + 1)'(lag_step);
    end

    // Per-channel operand selection.
    logic signed [15:0] a_cur, b_cur, dry_cur;
    logic signed [16:0] diff;
    logic signed [32:0] pitch_sum;
    logic signed [34:0] growl_sum;
    logic signed [ACC_W-1:0] round_adj;
    logic signed [17:0] quot;
    logic signed [15:0] sat_val;

    always_comb
    begin
        a_cur   = chan_reg ? a_r_reg : a_l_reg;
        b_cur   = chan_reg ? b_r_reg : $signed(ram_rdata_l);
        dry_cur = chan_reg ? dry_r_reg : dry_l_reg;
        diff    = {b_cur[15], b_cur} - {a_cur[15], a_cur};

        // Pitched sample with sixteen fractional bits: a * 65536 + frac * (b - a).
        pitch_sum = $signed({a_cur[15], a_cur, 16'b0}) + prod_reg[32:0];

        // Low-pass update: floor((3 * state + pitched) / 4).
        growl_sum = {{2{growl_reg[32]}}, growl_reg} + {{1{growl_reg[32]}}, growl_reg, 1'b0}
                  + {{3{pitched_reg[31]}}, pitched_reg};

        // Truncate the 32-fraction-bit mix toward zero, then saturate to int16.
        round_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(33'h0_FFFF_FFFF) : ACC_W'(0));
        quot      = round_adj[ACC_W-1:32];
        if (quot > 18'sd32767)
        begin
            sat_val = 16'sh7FFF;
        end
        else if (quot < -18'sd32768)
        begin
            sat_val = 16'sh8000;
        end
        else
        begin
            sat_val = quot[15:0];
        end
    end

    // Next-state and datapath logic.
    always_comb
    begin
        state_next     = state_reg;
        ratio_next     = ratio_reg;
        chan_cnt_next  = chan_cnt_reg;
        wpos_next      = wpos_reg;
        lag_next       = lag_reg;
        growl_next     = growl_reg;
        clr_cnt_next   = clr_cnt_reg;
        pos_a_next     = pos_a_reg;
        pos_b_next     = pos_b_reg;
        frac_next      = frac_reg;
        stereo_next    = stereo_reg;
        last_next      = last_reg;
        dry_l_next     = dry_l_reg;
        dry_r_next     = dry_r_reg;
        a_l_next       = a_l_reg;
        a_r_next       = a_r_reg;
        b_r_next       = b_r_reg;
        chan_next      = chan_reg;
        pitched_next   = pitched_reg;
        prod_next      = mul_p;
        acc_next       = acc_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        mul_a       = 33'sd0;
        mul_b       = 18'sd0;
        ram_we_l    = 1'b0;
        ram_we_r    = 1'b0;
        ram_waddr   = wpos_reg;
        ram_wdata_l = in_data.left_in;
        ram_wdata_r = in_data.right_in;
        ram_raddr   = pos_b_reg;

        // Configuration writes are taken in every state. The ratio is clamped on write.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PITCH_RATIO:
                begin
                    if (cfg_data < RATIO_MIN)
                    begin
                        ratio_next = RATIO_MIN;
                    end
                    else if (cfg_data > RATIO_MAX)
                    begin
                        ratio_next = RATIO_MAX;
                    end
                    else
                    begin
                        ratio_next = cfg_data;
                    end
                end
                CFG_CHANNEL_COUNT:
                begin
                    chan_cnt_next = cfg_data[1:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we_l     = 1'b1;
                ram_we_r     = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata_l  = 16'd0;
                ram_wdata_r  = 16'd0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    ram_we_l    = 1'b1;
                    ram_we_r    = chan_cnt_reg[1];
                    stereo_next = chan_cnt_reg[1];
                    last_next   = in_data.last_frame;
                    dry_l_next  = in_data.left_in;
                    dry_r_next  = in_data.right_in;
                    pos_a_next  = pos_a_new;
                    pos_b_next  = (pos_a_new == LAST_ADDR) ? '0 : pos_a_new + AW'(1);
                    frac_next   = 16'(17'h10000 - {1'b0, lag_frac});
                    res_r_next  = 16'sd0;
                    chan_next   = 1'b0;
                    wpos_next   = (wpos_reg == LAST_ADDR) ? '0 : wpos_reg + AW'(1);
                    if (lag_sum[LAG_W-1:0] > LAG_LIMIT)
                    begin
                        lag_next = LAG_HALF;
                    end
                    else
                    begin
                        lag_next = lag_sum[LAG_W-1:0];
                    end
                    state_next  = ST_READ_A;
                end
            end
            ST_READ_A:
            begin
                ram_raddr  = pos_a_reg;
                state_next = ST_READ_B;
            end
            ST_READ_B:
            begin
                a_l_next   = $signed(ram_rdata_l);
                a_r_next   = $signed(ram_rdata_r);
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                if (!chan_reg)
                begin
                    b_r_next = $signed(ram_rdata_r);
                end
                mul_a      = 33'(diff);
                mul_b      = $signed({2'b00, frac_reg});
                state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                pitched_next = pitch_sum[31:0];
                state_next   = ST_GROWL;
            end
            ST_GROWL:
            begin
                growl_next = growl_sum[34:2];
                mul_a      = 33'(pitched_reg);
                mul_b      = COEF_PITCHED;
                state_next = ST_MIX_LP;
            end
            ST_MIX_LP:
            begin
                acc_next   = prod_reg[ACC_W-1:0];
                mul_a      = growl_reg;
                mul_b      = COEF_LOWPASS;
                state_next = ST_MIX_DRY;
            end
            ST_MIX_DRY:
            begin
                acc_next   = acc_reg + prod_reg[ACC_W-1:0];
                mul_a      = 33'(dry_cur);
                mul_b      = COEF_DRY;
                state_next = ST_MIX_SUM;
            end
            ST_MIX_SUM:
            begin
                acc_next   = acc_reg + $signed({prod_reg[ACC_W-17:0], 16'b0});
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (chan_reg)
                begin
                    res_r_next = sat_val;
                    state_next = ST_DONE;
                end
                else
                begin
                    res_l_next = sat_val;
                    if (stereo_reg)
                    begin
                        chan_next  = 1'b1;
                        state_next = ST_INTERP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.left_out       = res_l_reg;
                    out_data_next.right_out      = res_r_reg;
                    out_data_next.last_frame_out = last_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ratio_reg     <= RATIO_RESET;
            chan_cnt_reg  <= CHAN_RESET;
            wpos_reg      <= '0;
            lag_reg       <= '0;
            growl_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ratio_reg     <= ratio_next;
            chan_cnt_reg  <= chan_cnt_next;
            wpos_reg      <= wpos_next;
            lag_reg       <= lag_next;
            growl_reg     <= growl_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset; each is loaded before it is used.
    always_ff @(posedge clk)
    begin
        pos_a_reg    <= pos_a_next;
        pos_b_reg    <= pos_b_next;
        frac_reg     <= frac_next;
        stereo_reg   <= stereo_next;
        last_reg     <= last_next;
        dry_l_reg    <= dry_l_next;
        dry_r_reg    <= dry_r_next;
        a_l_reg      <= a_l_next;
        a_r_reg      <= a_r_next;
        b_r_reg      <= b_r_next;
        chan_reg     <= chan_next;
        pitched_reg  <= pitched_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        res_l_reg    <= res_l_next;
        res_r_reg    <= res_r_next;
        out_data_reg <= out_data_next;
    end

    // The output register parts the two sides: a new frame may be accepted while a
    // finished transaction still waits on out_ready.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/pdg_ram.sv]
`default_nettype none

module pdg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/pdg_checker.sv]
`default_nettype none

module pdg_checker
    import pdg_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire in_frame_t             in_data,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire out_frame_t            out_data,
    input wire logic                  cfg_we,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // Once a frame is taken, the block stays busy while it works on it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input accepted again before the frame was processed");

    // A new result only appears at the end of a busy stretch.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a frame in process");

    // A frame taken with no result pending brings no result during the READ_A and READ_B states that follow.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
        else $error("result appeared too early after acceptance");

endmodule

bind pitch_down_growl_effect_unit pdg_checker u_pdg_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Geometry of the sample ring and the fixed-point rules of the effect.
    localparam int RING = 4096;
    localparam logic [28:0] LAG_LIMIT    = 29'(RING * 65536);
    localparam logic [28:0] LAG_RECENTER = 29'((RING / 2) * 65536);
    localparam logic [15:0] STEP_MIN     = 16'd29491;
    localparam logic [15:0] STEP_MAX     = 16'd49152;
    localparam longint MIX_PITCHED = 45875;
    localparam longint MIX_LOWPASS = 26214;
    localparam longint MIX_DRY     = 13107;
    localparam longint MIX_SCALE   = 64'sd4294967296;

    // Register indexes that decode to nothing inside the block.
    localparam logic [pdg_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [pdg_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Run control. Each drain after a phase outlasts the processing of a stereo frame, so
    // the pipeline is empty before the next phase starts.
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 400;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PHASE_FRAMES  = 60;
    localparam int LONG_RUN      = 400;
    localparam int PRINT_CAP     = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    pdg_pkg::in_frame_t   in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    pdg_pkg::out_frame_t  out_data;
    logic                 cfg_we = 1'b0;
    logic [pdg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pdg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pitch_down_growl_effect_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Shadow copy of the effect: the ring, both pointers, the shared low-pass
    // state and the two configuration registers as the block should hold them.
    logic signed [15:0] ring_copy [0:2*RING-1];
    logic [11:0]        wr_frame;
    logic [28:0]        lag_q;
    logic signed [32:0] growl_q;
    logic [15:0]        pitch_step;
    logic [1:0]         chan_mode;

    pdg_pkg::in_frame_t  frame_feed[$];
    pdg_pkg::out_frame_t expected_frames[$];
    pdg_pkg::out_frame_t want;

    int unsigned offered_total = 0;
    int unsigned accepted_total = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // Pacing state. The driver and the receiver own their own counters; the
    // stimulus process only sets the request flags.
    bit steady = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int ready_run = 0;
    int stall_run = 0;

    initial begin
        for (int i = 0; i < 2 * RING; i++)
        begin
            ring_copy[i] = '0;
        end
        wr_frame   = '0;
        lag_q      = '0;
        growl_q    = '0;
        pitch_step = pdg_pkg::RATIO_RESET;
        chan_mode  = pdg_pkg::CHAN_RESET;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    // One channel of the effect: interpolate between two ring frames, run the
    // shared low-pass once, then mix pitched, low-passed and dry signals.
    function automatic logic signed [15:0] mix_channel(input logic [11:0] pos_a,
                                                       input logic [11:0] pos_b,
                                                       input longint frac,
                                                       input bit ch,
                                                       input logic signed [15:0] dry);
        longint a;
        longint b;
        longint pitched;
        longint mix;
        longint q;
        a = ring_copy[{pos_a, ch}];
        b = ring_copy[{pos_b, ch}];
        pitched = a * 65536 + frac * (b - a);
        // An arithmetic shift by two is the floor of the division by four.
        growl_q = 33'((3 * longint'(growl_q) + pitched) >>> 2);
        mix = pitched * MIX_PITCHED + longint'(growl_q) * MIX_LOWPASS
            + longint'(dry) * MIX_DRY * 65536;
        // Signed division truncates toward zero before the saturation.
        q = mix / MIX_SCALE;
        if (q > 32767)
        begin
            return 16'sh7FFF;
        end
        if (q < -32768)
        begin
            return 16'sh8000;
        end
        return 16'(q);
    endfunction

    // Advances the shadow copy by one accepted frame and queues its result.
    task automatic predict_frame(input pdg_pkg::in_frame_t f);
        bit stereo;
        logic [12:0] lag_int;
        logic [15:0] lag_frac;
        logic [12:0] back;
        logic [11:0] pos_a;
        logic [11:0] pos_b;
        longint frac;
        pdg_pkg::out_frame_t r;
        stereo = (chan_mode >= 2'd2);
        // The new frame is written before the read, so a zero lag reads it back.
        ring_copy[{wr_frame, 1'b0}] = f.left_in;
        if (stereo)
        begin
            ring_copy[{wr_frame, 1'b1}] = f.right_in;
        end
        lag_int  = lag_q[28:16];
        lag_frac = lag_q[15:0];
        if (lag_frac == 16'd0)
        begin
            back = lag_int;
            frac = 0;
        end
        else
        begin
            back = lag_int + 13'd1;
            frac = 65536 - longint'(lag_frac);
        end
        pos_a = wr_frame - back[11:0];
        pos_b = pos_a + 12'd1;
        r.left_out  = mix_channel(pos_a, pos_b, frac, 1'b0, f.left_in);
        r.right_out = stereo ? mix_channel(pos_a, pos_b, frac, 1'b1, f.right_in) : 16'sd0;
        r.last_frame_out = f.last_frame;
        wr_frame = wr_frame + 12'd1;
        lag_q = lag_q + 29'(17'h10000 - {1'b0, pitch_step});
        // A read pointer that falls more than a whole ring behind is pulled to
        // half a ring behind the write pointer.
        if (lag_q > LAG_LIMIT)
        begin
            lag_q = LAG_RECENTER;
        end
        expected_frames.push_back(r);
    endtask

    // Writes one register on a falling edge and updates the shadow copy.
    task automatic write_reg(input logic [pdg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pdg_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            pdg_pkg::CFG_PITCH_RATIO:
            begin
                if (val < STEP_MIN)
                begin
                    pitch_step = STEP_MIN;
                end
                else if (val > STEP_MAX)
                begin
                    pitch_step = STEP_MAX;
                end
                else
                begin
                    pitch_step = val;
                end
            end
            pdg_pkg::CFG_CHANNEL_COUNT:
            begin
                chan_mode = val[1:0];
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Holds the sender back until every frame has been taken and answered,
    // then lets the pipeline run empty before anything else happens.
    task automatic settle();
        while (frame_feed.size() != 0 || accepted_total != offered_total
               || expected_frames.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic void push_frame(input logic signed [15:0] l,
                                       input logic signed [15:0] r,
                                       input logic last);
        pdg_pkg::in_frame_t f;
        f.left_in    = l;
        f.right_in   = r;
        f.last_frame = last;
        frame_feed.push_back(f);
    endfunction

    // Mixes full-scale values, which drive the mix into saturation, with small
    // values and uniformly random ones.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
            default: return 16'($urandom());
        endcase
    endfunction

    // Driver. A frame stays on the bus until the monitor has counted its
    // transaction; between bursts the sender idles in random gaps unless a steady stretch is asked for.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && accepted_total != offered_total)
        begin
            // Still waiting for the current transaction.
        end
        else if (gap_left > 0 && !steady)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (frame_feed.size() != 0)
        begin
            in_data  <= frame_feed.pop_front();
            in_valid <= 1'b1;
            offered_total++;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 20);
                gap_left   = $urandom_range(0, 12);
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Receiver. It stalls on its own run-length pattern, once holds off for a
    // long stretch so that the block backs up, and is always ready when the
    // stimulus asks for a steady stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (steady)
        begin
            out_ready <= 1'b1;
        end
        else if (ready_run > 0)
        begin
            out_ready <= 1'b1;
            ready_run--;
        end
        else if (stall_run > 0)
        begin
            out_ready <= 1'b0;
            stall_run--;
        end
        else
        begin
            ready_run = $urandom_range(1, 24);
            stall_run = $urandom_range(0, 7);
            out_ready <= 1'b1;
        end
    end

    // Monitor. Input transactions feed the predictor; output transactions are
    // compared field by field with the oldest expected frame.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_frame(in_data);
                accepted_total++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %p", out_data));
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (out_data.left_out !== want.left_out)
                    begin
                        report_mismatch($sformatf("left_out %0d, expected %0d",
                                                  out_data.left_out, want.left_out));
                    end
                    if (out_data.right_out !== want.right_out)
                    begin
                        report_mismatch($sformatf("right_out %0d, expected %0d",
                                                  out_data.right_out, want.right_out));
                    end
                    if (out_data.last_frame_out !== want.last_frame_out)
                    begin
                        report_mismatch($sformatf("last_frame_out %b, expected %b",
                                                  out_data.last_frame_out,
                                                  want.last_frame_out));
                    end
                end
            end
        end
    end

    // Watchdog over the whole run, including the clearing pass after reset.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus: directed frames at the register extremes, random phases over
    // many settings, then a steady run at the slowest read step that lets the
    // read pointer fall well behind the write pointer, and a short stereo tail.
    initial begin
        logic [15:0] ratio_val;
        logic [1:0]  chan_val;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A ratio of zero saturates to the lowest step; a count of three is
        // stereo. Writes to the spare indexes must change nothing.
        write_reg(pdg_pkg::CFG_PITCH_RATIO, 16'h0000);
        write_reg(pdg_pkg::CFG_CHANNEL_COUNT, 16'hFFFF);
        write_reg(CFG_SPARE_A, 16'h1234);
        write_reg(CFG_SPARE_B, 16'hFFFF);

        push_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        push_frame(16'sh8000, 16'sh8000, 1'b1);
        push_frame(16'sh7FFF, 16'sh8000, 1'b0);
        push_frame(16'sh8000, 16'sh7FFF, 1'b0);
        push_frame(16'sh0000, 16'sh0000, 1'b1);
        push_frame(-16'sd1, 16'sd1, 1'b0);
        push_frame(16'sd1, -16'sd1, 1'b0);
        push_frame(16'sh5555, 16'shAAAA, 1'b1);
        push_frame(16'shAAAA, 16'sh5555, 1'b0);
        push_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
        settle();

        // A ratio above the top saturates to the highest step; a count of zero
        // is mono, so the right slot of the ring keeps its old contents.
        write_reg(pdg_pkg::CFG_PITCH_RATIO, 16'hFFFF);
        write_reg(pdg_pkg::CFG_CHANNEL_COUNT, 16'h0000);
        push_frame(16'sh7FFF, 16'sh8000, 1'b0);
        push_frame(16'sh8000, 16'sh7FFF, 1'b1);
        push_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        push_frame(16'sh0000, -16'sd1, 1'b0);
        push_frame(-16'sd1, 16'sh7FFF, 1'b1);
        push_frame(16'sh8000, 16'sh8000, 1'b0);
        push_frame(16'sh3C3C, 16'shC3C3, 1'b0);
        push_frame(16'shC3C3, 16'sh3C3C, 1'b1);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    ratio_val = STEP_MAX;
                    chan_val  = 2'd2;
                end
                1:
                begin
                    ratio_val = STEP_MIN;
                    chan_val  = 2'd1;
                end
                2:
                begin
                    ratio_val = 16'($urandom_range(STEP_MIN, STEP_MAX));
                    chan_val  = 2'd3;
                end
                default:
                begin
                    ratio_val = 16'($urandom());
                    chan_val  = 2'($urandom_range(0, 3));
                end
            endcase
            write_reg(pdg_pkg::CFG_PITCH_RATIO, ratio_val);
            write_reg(pdg_pkg::CFG_CHANNEL_COUNT,
                      {14'($urandom()), chan_val});
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom()));
            end
            // In the first random phase the receiver stops for a long stretch
            // while the sender keeps offering, so the block fills and stalls.
            if (p == 0)
            begin
                long_hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_FRAMES; i++)
            begin
                push_frame(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0));
            end
            settle();
        end

        // Long mono run at the slowest read step with no idling on either side.
        write_reg(pdg_pkg::CFG_PITCH_RATIO, 16'd0);
        write_reg(pdg_pkg::CFG_CHANNEL_COUNT, 16'd1);
        steady = 1'b1;
        for (int i = 0; i < LONG_RUN; i++)
        begin
            push_frame(pick_sample(), pick_sample(), ($urandom_range(0, 15) == 0));
        end
        settle();
        steady = 1'b0;

        // A short stereo tail reads back right-channel slots left over from
        // the earlier stereo phases.
        write_reg(pdg_pkg::CFG_PITCH_RATIO, STEP_MAX);
        write_reg(pdg_pkg::CFG_CHANNEL_COUNT, 16'd2);
        for (int i = 0; i < 40; i++)
        begin
            push_frame(pick_sample(), pick_sample(), ($urandom_range(0, 3) == 0));
        end
        settle();

        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
